### hdl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared constants for the binary to decimal ascii converter: bcd
// correction constants, field widths and the ascii code of the zero digit.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    // width of one bcd digit
    localparam int unsigned BCD_DIGIT_BITS = 4;

    // double dabble correction: digits at or above the limit get the offset
    localparam logic [BCD_DIGIT_BITS-1:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [BCD_DIGIT_BITS-1:0] BCD_ADJ_OFFSET = 4'd3;

    // output field widths
    localparam int unsigned CHAR_BITS = 6;
    localparam int unsigned COUNT_BITS = 4;

    // ascii '0', truncated to the character field
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

endpackage

`default_nettype wire

### hdl/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts a binary value to its decimal digits as ascii characters.
// ----------------------------------------------------------------------------
// The s_ channel takes one unsigned value per item. The m_ channel returns
// one item per decimal digit, most significant first: the ascii code of the
// digit and the digit count in m_tdata, and m_tlast on the last digit. Zero
// gives the single digit '0'.
// The conversion is a double dabble pipeline of VALUE_BITS register stages,
// one binary bit per stage, followed by a digit emitter with an output
// register. The first digit of an item passes the stage registers, the
// emitter's digit register and the output register. The emitter sends one
// digit per cycle while the receiver is ready, digit_count digits per item
// (1 to MAX_DIGITS); the pipeline stalls only while its last stage is full
// and the emitter cannot take it. A receiver stall holds the output register
// and backs up into the pipeline; nothing is lost or repeated. Reset (aresetn
// low at a clock edge) empties the pipeline and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_unit #(
    parameter int unsigned VALUE_BITS = 31,
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: value [VALUE_BITS-1:0], zero padding above
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: digit_char [5:0], digit_count [9:6], zero padding [15:10]
    output logic [15:0]                          m_tdata,
    output logic                                 m_tlast
);

    localparam int unsigned BCD_W = MAX_DIGITS * bda_pkg::BCD_DIGIT_BITS;

    logic [VALUE_BITS:0]                  valid_pipe;
    logic [VALUE_BITS:0][BCD_W-1:0]       bcd_pipe;
    logic [VALUE_BITS-1:0][VALUE_BITS-1:0] rem_pipe;
    logic [VALUE_BITS:0]                  ovf_pipe;
    logic                                 pipe_en;
    logic                                 emit_ready;
    logic [bda_pkg::CHAR_BITS-1:0]        digit_char;
    logic [bda_pkg::COUNT_BITS-1:0]       digit_count;

    // pipeline moves whenever its last stage is empty or taken
    assign pipe_en  = ~valid_pipe[VALUE_BITS] | emit_ready;
    assign s_tready = pipe_en;

    // pipeline input
    assign valid_pipe[0] = s_tvalid;
    assign bcd_pipe[0]   = '0;
    assign rem_pipe[0]   = s_tdata[VALUE_BITS-1:0];
    assign ovf_pipe[0]   = 1'b0;

    // double dabble stages, one binary bit each
    for (genvar i = 0; i < int'(VALUE_BITS); i++) begin : g_stage
        if (i < int'(VALUE_BITS) - 1) begin : g_mid
            bda_dabble_stage #(
                .VALUE_BITS(VALUE_BITS),
                .MAX_DIGITS(MAX_DIGITS)
            ) u_stage (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (pipe_en),
                .valid_in (valid_pipe[i]),
                .bcd_in   (bcd_pipe[i]),
                .rem_in   (rem_pipe[i]),
                .ovf_in   (ovf_pipe[i]),
                .valid_out(valid_pipe[i+1]),
                .bcd_out  (bcd_pipe[i+1]),
                .rem_out  (rem_pipe[i+1]),
                .ovf_out  (ovf_pipe[i+1])
            );
        end else begin : g_end
            bda_dabble_stage #(
                .VALUE_BITS(VALUE_BITS),
                .MAX_DIGITS(MAX_DIGITS)
            ) u_stage (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (pipe_en),
                .valid_in (valid_pipe[i]),
                .bcd_in   (bcd_pipe[i]),
                .rem_in   (rem_pipe[i]),
                .ovf_in   (ovf_pipe[i]),
                .valid_out(valid_pipe[i+1]),
                .bcd_out  (bcd_pipe[i+1]),
                .rem_out  (),
                .ovf_out  (ovf_pipe[i+1])
            );
        end
    end

    // digit emitter and output register
    bda_emitter #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (valid_pipe[VALUE_BITS]),
        .in_ready (emit_ready),
        .in_bcd   (bcd_pipe[VALUE_BITS]),
        .in_ovf   (ovf_pipe[VALUE_BITS]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_char (digit_char),
        .out_count(digit_count),
        .out_last (m_tlast)
    );

    assign m_tdata = {6'b0, digit_count, digit_char};

endmodule

`default_nettype wire

### hdl/bda_dabble_stage.sv
// ----------------------------------------------------------------------------
// bda_dabble_stage
// One registered double dabble step: corrects every bcd digit, then shifts
// the next binary bit into the bcd register. Tracks digits lost off the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_dabble_stage #(
    parameter int unsigned VALUE_BITS = 31,
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         en,
    input  wire logic                                         valid_in,
    input  wire logic [MAX_DIGITS*bda_pkg::BCD_DIGIT_BITS-1:0] bcd_in,
    input  wire logic [VALUE_BITS-1:0]                        rem_in,
    input  wire logic                                         ovf_in,
    output logic                                              valid_out,
    output logic [MAX_DIGITS*bda_pkg::BCD_DIGIT_BITS-1:0]      bcd_out,
    output logic [VALUE_BITS-1:0]                             rem_out,
    output logic                                              ovf_out
);

    localparam int unsigned DW = bda_pkg::BCD_DIGIT_BITS;
    localparam int unsigned BCD_W = MAX_DIGITS * DW;

    logic [BCD_W-1:0]      adj;
    logic                  valid_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic                  ovf_reg;
    logic                  ovf_next;

    // add three to every digit of five or more
    always_comb begin
        for (int i = 0; i < int'(MAX_DIGITS); i++) begin
            if (bcd_in[i*DW +: DW] >= bda_pkg::BCD_ADJ_LIMIT) begin
                adj[i*DW +: DW] = bcd_in[i*DW +: DW] + bda_pkg::BCD_ADJ_OFFSET;
            end else begin
                adj[i*DW +: DW] = bcd_in[i*DW +: DW];
            end
        end
    end

    // shift left, next binary bit enters the lowest digit
    always_comb begin
        bcd_next = {adj[BCD_W-2:0], rem_in[VALUE_BITS-1]};
        rem_next = {rem_in[VALUE_BITS-2:0], 1'b0};
        ovf_next = ovf_in | adj[BCD_W-1];
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            bcd_reg <= bcd_next;
            rem_reg <= rem_next;
            ovf_reg <= ovf_next;
        end
    end

    assign valid_out = valid_reg;
    assign bcd_out   = bcd_reg;
    assign rem_out   = rem_reg;
    assign ovf_out   = ovf_reg;

endmodule

`default_nettype wire

### hdl/bda_emitter.sv
// ----------------------------------------------------------------------------
// bda_emitter
// Counts the significant digits of a converted value and sends them out one
// item per digit, most significant first, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_emitter #(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         in_valid,
    output logic                                              in_ready,
    input  wire logic [MAX_DIGITS*bda_pkg::BCD_DIGIT_BITS-1:0] in_bcd,
    input  wire logic                                         in_ovf,
    output logic                                              out_valid,
    input  wire logic                                         out_ready,
    output logic [bda_pkg::CHAR_BITS-1:0]                     out_char,
    output logic [bda_pkg::COUNT_BITS-1:0]                    out_count,
    output logic                                              out_last
);

    localparam int unsigned DW = bda_pkg::BCD_DIGIT_BITS;
    localparam int unsigned BCD_W = MAX_DIGITS * DW;
    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
    localparam int unsigned PW = $clog2(MAX_DIGITS);
    localparam int unsigned CH = bda_pkg::CHAR_BITS;
    localparam int unsigned CB = bda_pkg::COUNT_BITS;

    logic [CW-1:0]    in_cnt;
    logic [CW-1:0]    in_cnt_m1;
    logic             out_free;
    logic             load;
    logic             emit;
    logic [DW-1:0]    cur_digit;
    logic [CW+CB-1:0] cnt_ext;

    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic [PW-1:0]    pos_reg;
    logic [PW-1:0]    pos_next;
    logic             busy_reg;
    logic             busy_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CH-1:0]    char_reg;
    logic [CH-1:0]    char_next;
    logic [CB-1:0]    count_reg;
    logic [CB-1:0]    count_next;
    logic             last_reg;
    logic             last_next;

    // significant digit count, at least one, full width when digits were lost
    always_comb begin
        in_cnt = CW'(1);
        for (int i = 0; i < int'(MAX_DIGITS); i++) begin
            if (in_bcd[i*DW +: DW] != '0) begin
                in_cnt = CW'(i + 1);
            end
        end
        if (in_ovf) begin
            in_cnt = CW'(MAX_DIGITS);
        end
        in_cnt_m1 = in_cnt - CW'(1);
    end

    // handshake
    always_comb begin
        out_free = ~out_valid_reg | out_ready;
        in_ready = ~busy_reg | (out_free & (pos_reg == '0));
        load     = in_valid & in_ready;
        emit     = busy_reg & out_free;
    end

    // digit under the read position
    assign cur_digit = bcd_reg[pos_reg*DW +: DW];
    assign cnt_ext   = {{CB{1'b0}}, cnt_reg};

    // sequencing of the digit walk
    always_comb begin
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        busy_next = busy_reg;
        if (emit) begin
            pos_next = pos_reg - PW'(1);
            if (pos_reg == '0) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            bcd_next  = in_bcd;
            cnt_next  = in_cnt;
            pos_next  = in_cnt_m1[PW-1:0];
            busy_next = 1'b1;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            char_next      = bda_pkg::ASCII_ZERO + CH'(cur_digit);
            count_next     = cnt_ext[CB-1:0];
            last_next      = (pos_reg == '0);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        char_reg  <= char_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire
